@@ rtl/mrw_pkg.sv @@
package mrw_pkg;

  // Limb and divisor width
  localparam int unsigned LIMB_W = 64;
  // Shift register holds the remainder's high word and the limb
  localparam int unsigned WIDE_W = 2 * LIMB_W;
  // Iteration counter must hold the full 128-step count
  localparam int unsigned CNT_W = $clog2(WIDE_W + 1);
  localparam logic [CNT_W-1:0] ITER_FULL = CNT_W'(WIDE_W);
  localparam logic [CNT_W-1:0] ITER_HALF = CNT_W'(LIMB_W);

  // Configuration port
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_DIVISOR = 1'b0;
  localparam logic [LIMB_W-1:0] DIVISOR_RESET = LIMB_W'(1);

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // take a new limb
    logic step;      // one restoring iteration
    logic out_load;  // capture the result word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic iter_done; // iteration counter at zero
  } status_t;

endpackage

@@ rtl/mrw_if.sv @@
interface mrw_in_if;
  logic valid;
  logic ready;
  logic [mrw_pkg::LIMB_W-1:0] limb;
  logic first;
  logic last;

  modport source (output valid, output limb, output first, output last, input ready);
  modport sink (input valid, input limb, input first, input last, output ready);
endinterface

interface mrw_out_if;
  logic valid;
  logic ready;
  logic [mrw_pkg::LIMB_W-1:0] remainder;
  logic divisible;

  modport source (output valid, output remainder, output divisible, input ready);
  modport sink (input valid, input remainder, input divisible, output ready);
endinterface

@@ rtl/mrw_dp.sv @@
module mrw_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  mrw_pkg::cmd_t               cmd,
  output mrw_pkg::status_t            status,
  input  logic [mrw_pkg::LIMB_W-1:0]  divisor,
  input  logic [mrw_pkg::LIMB_W-1:0]  limb,
  input  logic                        first,
  output logic [mrw_pkg::LIMB_W-1:0]  remainder,
  output logic                        divisible
);

  logic [mrw_pkg::LIMB_W-1:0] rem;
  logic [mrw_pkg::LIMB_W-1:0] rem_next;
  logic [mrw_pkg::WIDE_W-1:0] sh;
  logic [mrw_pkg::WIDE_W-1:0] sh_next;
  logic [mrw_pkg::CNT_W-1:0]  cnt;
  logic [mrw_pkg::CNT_W-1:0]  cnt_next;

  logic [mrw_pkg::LIMB_W-1:0] hi;
  logic [mrw_pkg::LIMB_W-1:0] shifted;
  logic [mrw_pkg::LIMB_W:0]   trial;

  // Running remainder as the new number starts
  assign hi = first ? '0 : rem;

  // One restoring step: shift in the next bit, subtract when it fits
  assign shifted = {rem[mrw_pkg::LIMB_W-2:0], sh[mrw_pkg::WIDE_W-1]};
  assign trial   = {rem[mrw_pkg::LIMB_W-1], shifted} - {1'b0, divisor};

  always_comb begin
    rem_next = rem;
    sh_next  = sh;
    cnt_next = cnt;
    if (cmd.load) begin
      if (divisor == '0) begin
        // No reduction: the limb stands as the remainder
        rem_next = limb;
        cnt_next = '0;
      end else if (hi < divisor) begin
        // High word already reduced: only the limb's bits remain
        rem_next = hi;
        sh_next  = {limb, {mrw_pkg::LIMB_W{1'b0}}};
        cnt_next = mrw_pkg::ITER_HALF;
      end else begin
        rem_next = '0;
        sh_next  = {hi, limb};
        cnt_next = mrw_pkg::ITER_FULL;
      end
    end else if (cmd.step) begin
      rem_next = trial[mrw_pkg::LIMB_W] ? shifted : trial[mrw_pkg::LIMB_W-1:0];
      sh_next  = {sh[mrw_pkg::WIDE_W-2:0], 1'b0};
      cnt_next = cnt - 1'b1;
    end
  end

  // Running remainder and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      cnt <= '0;
    end else begin
      rem <= rem_next;
      cnt <= cnt_next;
    end
  end

  // Bit queue
  always_ff @(posedge clk) begin
    sh <= sh_next;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      remainder <= rem;
      divisible <= (rem == '0);
    end
  end

  assign status.iter_done = (cnt == '0);

endmodule

@@ rtl/mrw_ctrl.sv @@
module mrw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output mrw_pkg::cmd_t      cmd,
  input  mrw_pkg::status_t   status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_q;
  logic   slot_free;

  // Output register can take a word now
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!status.iter_done) begin
          cmd.step = 1'b1;
        end else if (last_q) begin
          state_next = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, last mark and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        last_q <= in_last;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/multiword_remainder_by_word.sv @@
// Remainder of a multi-limb number by a 64-bit divisor, one limb at a time.
// Each limb runs a radix-2 restoring loop over 64 bits when the running remainder is
// below the divisor and over 128 bits otherwise; a zero divisor skips the loop. A last
// limb also loads the output register, which waits while the output is stalled.
// A new limb is taken only when idle, so no limb is taken before the last one is through.
// Reset (rst, synchronous): divisor returns to 1, running remainder to zero.
module multiword_remainder_by_word (
  input  logic                         clk,
  input  logic                         rst,
  mrw_in_if.sink                       limbs,
  mrw_out_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrw_pkg::ADDR_W-1:0]   paddr,
  input  logic [mrw_pkg::DATA_W-1:0]   pwdata,
  output logic [mrw_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [mrw_pkg::LIMB_W-1:0]    divisor;
  logic [mrw_pkg::REG_IDX_W-1:0] reg_idx;
  mrw_pkg::cmd_t                 cmd;
  mrw_pkg::status_t              status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mrw_pkg::ADDR_W-1 -: mrw_pkg::REG_IDX_W];

  // Divisor register write
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= mrw_pkg::DIVISOR_RESET;
    end else if (psel && penable && pwrite && reg_idx == mrw_pkg::REG_DIVISOR) begin
      divisor <= pwdata;
    end
  end

  // Register read
  always_comb begin
    case (reg_idx)
      mrw_pkg::REG_DIVISOR: prdata = divisor;
      default:              prdata = '0;
    endcase
  end

  mrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (limbs.valid),
    .in_ready  (limbs.ready),
    .in_last   (limbs.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .status    (status)
  );

  mrw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .divisor   (divisor),
    .limb      (limbs.limb),
    .first     (limbs.first),
    .remainder (result.remainder),
    .divisible (result.divisible)
  );

endmodule

@@ rtl/mrw_check.sv @@
module mrw_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mrw_pkg::LIMB_W-1:0]  remainder,
  input logic                        divisible
);

  // Busy after a limb is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("limb accepted while previous limb still in work");

  // Flag agrees with the remainder
  a_divisible_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (divisible == (remainder == '0)))
    else $error("divisible flag disagrees with remainder");

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(remainder) && $stable(divisible))
    else $error("output word changed while stalled");

  // Reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind multiword_remainder_by_word mrw_check u_mrw_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (limbs.valid),
  .in_ready  (limbs.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .remainder (result.remainder),
  .divisible (result.divisible)
);

@@ dv/multiword_remainder_by_word_test.sv @@
module multiword_remainder_by_word_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMB_W = mrw_pkg::LIMB_W;
  localparam int unsigned WIDE_W = mrw_pkg::WIDE_W;
  localparam int unsigned ADDR_W = mrw_pkg::ADDR_W;
  localparam int unsigned DATA_W = mrw_pkg::DATA_W;

  localparam int unsigned HALF_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 10;
  // Drain margin covers the longest limb, a full 128-bit loop, and the output register load
  localparam int unsigned DRAIN_CYCLES = 140;
  // Registers are 64 bits wide, so each one takes 8 bytes of address space
  localparam int unsigned REG_SHIFT = 3;
  localparam logic [ADDR_W-1:0] ADDR_DIVISOR = ADDR_W'(mrw_pkg::REG_DIVISOR) << REG_SHIFT;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_DIVISOR + (ADDR_W'(1) << REG_SHIFT);
  localparam int unsigned PHASES = 9;
  localparam int unsigned LIMBS_PER_PHASE = 72;

  typedef struct packed {
    logic [LIMB_W-1:0] remainder;
    logic divisible;
  } rem_word_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mrw_in_if limb_ch ();
  mrw_out_if rem_ch ();

  // Predicted state of the block
  logic [LIMB_W-1:0] divisor_cfg = mrw_pkg::DIVISOR_RESET;
  logic [LIMB_W-1:0] running_rem = '0;
  rem_word_t remainders_due[$];

  int unsigned errors = 0;
  int unsigned limbs_sent = 0;
  int unsigned numbers_sent = 0;
  int unsigned divisor_writes = 0;
  int unsigned words_checked = 0;
  int unsigned stall_left = 0;
  bit steady = 1'b0;

  multiword_remainder_by_word i_dut (
    .clk     (clk),
    .rst     (rst),
    .limbs   (limb_ch),
    .result  (rem_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Reduce the 128-bit value {carry_in, word} modulo d; a zero divisor keeps the limb
  function automatic logic [LIMB_W-1:0] fold_limb(logic [LIMB_W-1:0] carry_in,
                                                  logic [LIMB_W-1:0] word,
                                                  logic [LIMB_W-1:0] d);
    logic [WIDE_W-1:0] wide;
    wide = {carry_in, word};
    if (d == '0) return word;
    return LIMB_W'(wide % WIDE_W'(d));
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [LIMB_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return LIMB_W'($urandom_range(15));
      3: return LIMB_W'(1) << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [LIMB_W-1:0] pick_divisor(int unsigned phase);
    logic [LIMB_W-1:0] d;
    case (phase % 8)
      0: d = LIMB_W'(1);
      1: d = '1;
      2: d = LIMB_W'($urandom_range(7, 2));
      3: d = LIMB_W'(1) << $urandom_range(63, 1);
      4: d = '1 - LIMB_W'($urandom_range(15));
      5: d = {32'h0, $urandom};
      6: d = {1'b1, $urandom, 31'($urandom)};
      default: d = {$urandom, $urandom};
    endcase
    if (d == '0) d = LIMB_W'(1);
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [LIMB_W-1:0] got,
                                 input logic [LIMB_W-1:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Hand one limb to the block and record the remainder it should produce
  task automatic send_limb(input logic [LIMB_W-1:0] word, input logic is_first,
                           input logic is_last);
    int unsigned gap;
    logic [LIMB_W-1:0] base;
    rem_word_t due;
    gap = pick_gap();
    if (gap != 0) begin
      limb_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    limb_ch.valid <= 1'b1;
    limb_ch.limb <= word;
    limb_ch.first <= is_first;
    limb_ch.last <= is_last;
    do @(posedge clk); while (!limb_ch.ready);
    base = is_first ? '0 : running_rem;
    running_rem = fold_limb(base, word, divisor_cfg);
    limbs_sent++;
    if (is_last) begin
      due.remainder = running_rem;
      due.divisible = (running_rem == '0);
      remainders_due.push_back(due);
    end
  endtask

  // Hold the sender until every expected word has come, then let the block finish
  task automatic drain_block(input int unsigned extra_cycles);
    limb_ch.valid <= 1'b0;
    do @(posedge clk); while (remainders_due.size() != 0);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr[ADDR_W-1:REG_SHIFT] == mrw_pkg::REG_DIVISOR) begin
      divisor_cfg = data;
      divisor_writes++;
    end
  endtask

  // Limbs straight after reset: no first mark, divisor still at its reset value
  task automatic test_reset_state();
    send_limb({$urandom, $urandom}, 1'b0, 1'b0);
    send_limb('1, 1'b0, 1'b1);
    send_limb('1, 1'b1, 1'b1);
    send_limb('0, 1'b1, 1'b1);
    numbers_sent += 3;
  endtask

  // Largest divisor, and one with only the top bit set
  task automatic test_extreme_divisor();
    drain_block(DRAIN_CYCLES);
    write_reg(ADDR_DIVISOR, '1);
    send_limb('1, 1'b1, 1'b1);
    send_limb(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
    send_limb('0, 1'b1, 1'b1);
    send_limb(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0);
    send_limb('1, 1'b0, 1'b0);
    send_limb(64'h8000_0000_0000_0000, 1'b0, 1'b1);
    drain_block(DRAIN_CYCLES);
    write_reg(ADDR_DIVISOR, 64'h8000_0000_0000_0000);
    send_limb('1, 1'b1, 1'b0);
    send_limb('1, 1'b0, 1'b1);
    numbers_sent += 5;
  endtask

  // Numbers that pick up the remainder left by the previous one
  task automatic test_continuation();
    drain_block(DRAIN_CYCLES);
    write_reg(ADDR_DIVISOR, 64'd1000003);
    send_limb(pick_word(), 1'b1, 1'b1);
    send_limb(pick_word(), 1'b0, 1'b1);
    send_limb(pick_word(), 1'b0, 1'b0);
    send_limb(pick_word(), 1'b0, 1'b1);
    send_limb(64'd2000006, 1'b1, 1'b1);
    numbers_sent += 4;
  endtask

  // Change the divisor in the middle of a number; a write to the unused slot must not land
  task automatic test_divisor_change();
    drain_block(DRAIN_CYCLES);
    write_reg(ADDR_DIVISOR, {1'b1, $urandom, 31'($urandom)});
    send_limb('1, 1'b1, 1'b0);
    drain_block(DRAIN_CYCLES);
    write_reg(ADDR_DIVISOR, 64'd3);
    write_reg(ADDR_UNUSED, '0);
    send_limb(pick_word(), 1'b0, 1'b0);
    send_limb(pick_word(), 1'b0, 1'b1);
    send_limb(64'd9, 1'b1, 1'b1);
    numbers_sent += 2;
  endtask

  // Well-formed numbers of random length under several divisors, with some broken ones
  task automatic test_random_numbers();
    int unsigned phase;
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    logic noisy;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_block(DRAIN_CYCLES);
      write_reg(ADDR_DIVISOR, pick_divisor(phase));
      steady = (phase == 7);
      sent = 0;
      while (sent < LIMBS_PER_PHASE) begin
        noisy = ($urandom_range(9) == 0);
        len = ($urandom_range(3) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
        for (k = 0; k < len; k++) begin
          if (noisy) begin
            send_limb(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
          end else begin
            send_limb(pick_word(), k == 0, k == len - 1);
          end
        end
        sent += len;
        numbers_sent++;
        // Pause now and then until all outstanding words are back
        if ($urandom_range(19) == 0) drain_block(0);
      end
    end
    steady = 1'b0;
  endtask

  // Receiver side: random stalls between ready cycles
  always @(posedge clk) begin
    if (rst) begin
      rem_ch.ready <= 1'b0;
    end else if (steady) begin
      rem_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      rem_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rem_ch.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Compare each accepted word with the oldest expected one
  always @(posedge clk) begin
    rem_word_t due;
    if (!rst && rem_ch.valid && rem_ch.ready) begin
      if (remainders_due.size() == 0) begin
        report_mismatch("unexpected word", rem_ch.remainder, '0);
      end else begin
        due = remainders_due.pop_front();
        if (rem_ch.remainder !== due.remainder)
          report_mismatch("remainder", rem_ch.remainder, due.remainder);
        if (rem_ch.divisible !== due.divisible)
          report_mismatch("divisible", LIMB_W'(rem_ch.divisible), LIMB_W'(due.divisible));
        words_checked++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    limb_ch.valid = 1'b0;
    limb_ch.limb = '0;
    limb_ch.first = 1'b0;
    limb_ch.last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_extreme_divisor();
    test_continuation();
    test_divisor_change();
    test_random_numbers();
    drain_block(DRAIN_CYCLES);
    $display("Sent %0d limbs in %0d numbers over %0d divisor settings",
             limbs_sent, numbers_sent, divisor_writes);
    $display("Checked %0d remainder words, %0d errors", words_checked, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
